// ----- sv/cpfc_pkg.sv -----
// shared types, codes and the crc byte update for the frame checker
// used by every module of the block; depends on nothing else
package cpfc_pkg;

  localparam int MAX_PARAMS_DEFAULT = 64;

  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [10:0] COUNT_MAX = 11'h7FF;

  localparam logic [7:0] OWN_ID_RESET      = 8'hE1;
  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

  // register indexes on the configuration port
  localparam logic [1:0] REG_OWN_ID      = 2'd0;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd1;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd2;

  localparam logic [2:0] ROLE_HEADER      = 3'd0;
  localparam logic [2:0] ROLE_ID          = 3'd1;
  localparam logic [2:0] ROLE_LENGTH      = 3'd2;
  localparam logic [2:0] ROLE_INSTRUCTION = 3'd3;
  localparam logic [2:0] ROLE_PARAMETER   = 3'd4;
  localparam logic [2:0] ROLE_CRC         = 3'd5;

  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_FRAMING = 2'd1;
  localparam logic [1:0] VERDICT_NOADDR  = 2'd2;
  localparam logic [1:0] VERDICT_CRC     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
    logic       clear_errors;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic       frame_done;
    logic [1:0] verdict;
    logic [6:0] param_count;
    logic [1:0] sticky_errors;
  } res_word_t;

  // control from the frame tracker to the crc unit
  typedef struct packed {
    logic advance;
    logic feed;
    logic rearm;
  } crc_ctrl_t;

  typedef struct packed {
    logic [15:0] crc_next;
    logic [15:0] rx_crc;
  } crc_stat_t;

  // msb-first crc-16 update over one byte
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/cpfc_crc.sv -----
// running crc register and the two-byte delay line in front of it
// depends on cpfc_pkg for the control structs and the byte update
module cpfc_crc (
  input  logic                 clk,
  input  logic                 rst,
  input  cpfc_pkg::crc_ctrl_t  ctrl,
  input  logic [7:0]           data_byte,
  output cpfc_pkg::crc_stat_t  stat
);

  logic [15:0] crc;
  logic [7:0]  delay0;
  logic [7:0]  delay1;
  logic [15:0] crc_next;

  always_comb begin
    crc_next = ctrl.feed ? cpfc_pkg::crc16_feed(crc, delay0) : crc;
  end

  assign stat.crc_next = crc_next;
  assign stat.rx_crc   = {data_byte, delay1};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc    <= '0;
      delay0 <= '0;
      delay1 <= '0;
    end else if (ctrl.advance) begin
      if (ctrl.rearm) begin
        crc    <= '0;
        delay0 <= '0;
        delay1 <= '0;
      end else begin
        crc    <= crc_next;
        delay0 <= delay1;
        delay1 <= data_byte;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a finished frame leaves the crc cleared for the next one
  a_rearm_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance && ctrl.rearm |=> crc == 16'h0000 && delay1 == 8'h00)
    else $error("crc not cleared after frame end");
`endif

endmodule

// ----- sv/cpfc_frame.sv -----
// frame position tracking, byte roles, verdict and sticky error flags
// depends on cpfc_pkg; takes the crc result from cpfc_crc
module cpfc_frame #(
  parameter int MAX_PARAMS = cpfc_pkg::MAX_PARAMS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  cpfc_pkg::rx_word_t   rx,
  input  logic [7:0]           own_id,
  input  logic [7:0]           sync_first,
  input  logic [7:0]           sync_second,
  input  cpfc_pkg::crc_stat_t  crc_stat,
  output cpfc_pkg::crc_ctrl_t  crc_ctrl,
  output cpfc_pkg::res_word_t  res
);

  localparam logic [16:0] LEN_LIMIT = 17'(MAX_PARAMS + 3);

  logic [10:0] byte_count;
  logic [15:0] length_value;
  logic        header_good;
  logic        id_good;
  logic [1:0]  error_flags;

  logic [10:0] byte_count_next;
  logic [15:0] length_value_next;
  logic        header_good_next;
  logic        id_good_next;
  logic [1:0]  error_flags_next;
  logic [2:0]  role;
  logic [1:0]  verdict;
  logic [6:0]  pcount;
  logic [16:0] total;
  logic [16:0] len_ext;
  logic        len_bad;

  always_comb begin
    len_ext = {1'b0, length_value};
    if (byte_count < 11'd2) begin
      role = cpfc_pkg::ROLE_HEADER;
    end else if (byte_count == 11'd2) begin
      role = cpfc_pkg::ROLE_ID;
    end else if (byte_count < 11'd5) begin
      role = cpfc_pkg::ROLE_LENGTH;
    end else if (byte_count == 11'd5) begin
      role = cpfc_pkg::ROLE_INSTRUCTION;
    end else if (17'(byte_count) < len_ext + 17'd3) begin
      role = cpfc_pkg::ROLE_PARAMETER;
    end else begin
      role = cpfc_pkg::ROLE_CRC;
    end

    header_good_next = header_good
      & ~(byte_count == 11'd0 && rx.data_byte != sync_first)
      & ~(byte_count == 11'd1 && rx.data_byte != sync_second);
    id_good_next = id_good & ~(byte_count == 11'd2 && rx.data_byte != own_id);

    length_value_next = length_value;
    if (byte_count == 11'd3) begin
      length_value_next[7:0] = rx.data_byte;
    end
    if (byte_count == 11'd4) begin
      length_value_next[15:8] = rx.data_byte;
    end

    byte_count_next = (byte_count == cpfc_pkg::COUNT_MAX) ? byte_count : byte_count + 11'd1;

    // length rule on the length field as updated by this byte
    total   = 17'(byte_count) + 17'd1;
    len_bad = (length_value_next < 16'd3) || ({1'b0, length_value_next} > LEN_LIMIT)
           || (total != {1'b0, length_value_next} + 17'd5);

    verdict = cpfc_pkg::VERDICT_OK;
    pcount  = '0;
    if (rx.end_of_frame) begin
      if (!header_good_next) begin
        verdict = cpfc_pkg::VERDICT_FRAMING;
      end else if (!id_good_next) begin
        verdict = cpfc_pkg::VERDICT_NOADDR;
      end else if (len_bad) begin
        verdict = cpfc_pkg::VERDICT_FRAMING;
      end else if (crc_stat.crc_next != crc_stat.rx_crc) begin
        verdict = cpfc_pkg::VERDICT_CRC;
      end else begin
        pcount = 7'(length_value_next - 16'd3);
      end
    end

    // clear takes effect before this byte's error is recorded
    error_flags_next = rx.clear_errors ? 2'b00 : error_flags;
    error_flags_next[0] = error_flags_next[0] | (verdict == cpfc_pkg::VERDICT_FRAMING);
    error_flags_next[1] = error_flags_next[1] | (verdict == cpfc_pkg::VERDICT_CRC);
  end

  assign crc_ctrl.advance = accept;
  assign crc_ctrl.feed    = byte_count >= 11'd2;
  assign crc_ctrl.rearm   = rx.end_of_frame;

  assign res.byte_out      = rx.data_byte;
  assign res.byte_role     = role;
  assign res.frame_done    = rx.end_of_frame;
  assign res.verdict       = verdict;
  assign res.param_count   = pcount;
  assign res.sticky_errors = error_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      length_value <= '0;
      header_good  <= 1'b1;
      id_good      <= 1'b1;
      error_flags  <= '0;
    end else if (accept) begin
      error_flags <= error_flags_next;
      if (rx.end_of_frame) begin
        byte_count   <= '0;
        length_value <= '0;
        header_good  <= 1'b1;
        id_good      <= 1'b1;
      end else begin
        byte_count   <= byte_count_next;
        length_value <= length_value_next;
        header_good  <= header_good_next;
        id_good      <= id_good_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    accept && rx.end_of_frame |=> byte_count == 11'd0 && header_good && id_good)
    else $error("frame state not re-armed after last word");
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    accept && !rx.end_of_frame && byte_count == cpfc_pkg::COUNT_MAX
      |=> byte_count == cpfc_pkg::COUNT_MAX)
    else $error("byte counter wrapped");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    !rx.end_of_frame |-> verdict == cpfc_pkg::VERDICT_OK && pcount == 7'd0)
    else $error("verdict shown on a word that does not end a frame");
`endif

endmodule

// ----- sv/cpfc_skid.sv -----
// result register with a skid stage behind it
// depends on cpfc_pkg for the result word type
module cpfc_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpfc_pkg::res_word_t  push_data,
  output logic                 full,
  output logic                 res_valid,
  input  logic                 res_stall,
  output cpfc_pkg::res_word_t  res_data
);

  logic                sk_valid;
  cpfc_pkg::res_word_t sk_data;

  assign full = sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      // output moves or is empty: refill from skid first
      if (sk_valid) begin
        res_valid <= 1'b1;
        res_data  <= sk_data;
        sk_valid  <= 1'b0;
      end else begin
        res_valid <= push;
        res_data  <= push_data;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
      sk_data  <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> res_valid)
    else $error("skid holds a word while output is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    push && res_valid && res_stall |=> sk_valid)
    else $error("word lost while output stalled");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> !push)
    else $error("word pushed into a full skid");
`endif

endmodule

// ----- sv/crc16_packet_frame_checker.sv -----
// each result is registered, in the output register or, while the output is stalled, in the skid stage
// throughput: one byte per cycle while the skid stage is empty; crc byte update and frame tracking sit in one stage
// the skid stage lets one more byte in while a result is stalled
// reset (rst, synchronous, active high) restores registers and clears all frame state
// top level of the frame checker: apb registers, tracker, crc unit, result buffer
// depends on cpfc_pkg, cpfc_crc, cpfc_frame and cpfc_skid
module crc16_packet_frame_checker #(
  parameter int MAX_PARAMS = cpfc_pkg::MAX_PARAMS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  cpfc_pkg::rx_word_t  rx_data,
  output logic                res_valid,
  input  logic                res_stall,
  output cpfc_pkg::res_word_t res_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] own_id;
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic       accept;
  logic       skid_full;

  cpfc_pkg::crc_ctrl_t crc_ctrl;
  cpfc_pkg::crc_stat_t crc_stat;
  cpfc_pkg::res_word_t res_word;

  assign pready   = 1'b1;
  assign rx_stall = skid_full;
  assign accept   = rx_valid && !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id      <= cpfc_pkg::OWN_ID_RESET;
      sync_first  <= cpfc_pkg::SYNC_FIRST_RESET;
      sync_second <= cpfc_pkg::SYNC_SECOND_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cpfc_pkg::REG_OWN_ID:      own_id      <= pwdata[7:0];
        cpfc_pkg::REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        cpfc_pkg::REG_SYNC_SECOND: sync_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cpfc_pkg::REG_OWN_ID:      prdata = {24'h0, own_id};
      cpfc_pkg::REG_SYNC_FIRST:  prdata = {24'h0, sync_first};
      cpfc_pkg::REG_SYNC_SECOND: prdata = {24'h0, sync_second};
      default:                   prdata = '0;
    endcase
  end

  cpfc_frame #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx          (rx_data),
    .own_id      (own_id),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .crc_stat    (crc_stat),
    .crc_ctrl    (crc_ctrl),
    .res         (res_word)
  );

  cpfc_crc u_crc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (crc_ctrl),
    .data_byte (rx_data.data_byte),
    .stat      (crc_stat)
  );

  cpfc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_word),
    .full      (skid_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ----- tb/sv/tb_crc16_packet_frame_checker.sv -----
// self-checking bench for crc16_packet_frame_checker: a directed table of frames,
// then random framed traffic under several header and id settings
// depends on cpfc_pkg and the checker rtl; predicts every result word in-bench
`timescale 1ns / 100ps

module tb_crc16_packet_frame_checker;
  import cpfc_pkg::*;

  localparam int PARAM_LIMIT = MAX_PARAMS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 80;
  localparam int MAX_LINES = 50;

  localparam int FILL_NONE = 0;
  localparam int FILL_CRC_LO = 1;
  localparam int FILL_CRC_HI = 2;

  localparam logic [1:0] STICKY_NONE = 2'b00;
  localparam logic [1:0] STICKY_FRAMING = 2'b01;
  localparam logic [1:0] STICKY_CRC = 2'b10;

  typedef enum int {
    FRAME_GOOD, FRAME_BAD_CRC, FRAME_WRONG_ID, FRAME_BAD_HEADER, FRAME_BAD_COUNT,
    FRAME_SHORT_LEN, FRAME_OVERSIZE, FRAME_NOISE
  } frame_kind_t;

  typedef struct {
    rx_word_t  w;
    int        fill;
    bit        typed;
    res_word_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  rx_word_t    rx_data = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_word_t   res_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers and frame state
  logic [7:0]  cfg_own_id;
  logic [7:0]  cfg_sync_first;
  logic [7:0]  cfg_sync_second;
  logic [15:0] crc_acc;
  logic [7:0]  delay_line [2];
  logic [10:0] byte_idx;
  logic [15:0] frame_len;
  logic        header_ok;
  logic        id_ok;
  logic [1:0]  sticky;

  res_word_t expected_words [$];
  stim_row_t directed_rows [$];
  int mismatch_count = 0;
  int words_sent = 0;
  int words_seen = 0;
  bit rx_calm = 1'b0;
  bit res_calm = 1'b0;

  crc16_packet_frame_checker #(.MAX_PARAMS(PARAM_LIMIT)) u_top (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_data(rx_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void rearm_tracker();
    crc_acc = '0;
    delay_line[0] = '0;
    delay_line[1] = '0;
    byte_idx = '0;
    frame_len = '0;
    header_ok = 1'b1;
    id_ok = 1'b1;
  endfunction

  // expected result word for one accepted byte, advancing the frame state
  function automatic res_word_t track_byte(input rx_word_t w);
    res_word_t r;
    logic [15:0] rx_crc;
    logic [10:0] idx;
    int len;
    r = '0;
    idx = byte_idx;
    if (w.clear_errors) sticky = STICKY_NONE;

    if (idx < 2) r.byte_role = ROLE_HEADER;
    else if (idx == 2) r.byte_role = ROLE_ID;
    else if (idx < 5) r.byte_role = ROLE_LENGTH;
    else if (idx == 5) r.byte_role = ROLE_INSTRUCTION;
    else if (int'(idx) < int'(frame_len) + 3) r.byte_role = ROLE_PARAMETER;
    else r.byte_role = ROLE_CRC;

    if (idx == 0 && w.data_byte != cfg_sync_first) header_ok = 1'b0;
    if (idx == 1 && w.data_byte != cfg_sync_second) header_ok = 1'b0;
    if (idx == 2 && w.data_byte != cfg_own_id) id_ok = 1'b0;
    if (idx == 3) frame_len[7:0] = w.data_byte;
    if (idx == 4) frame_len[15:8] = w.data_byte;

    // bytes reach the crc two places late, so the trailing crc is never covered
    if (idx >= 2) crc_acc = crc16_step(crc_acc, delay_line[0]);
    rx_crc = {w.data_byte, delay_line[1]};
    delay_line[0] = delay_line[1];
    delay_line[1] = w.data_byte;
    if (byte_idx != COUNT_MAX) byte_idx = byte_idx + 1'b1;

    r.byte_out = w.data_byte;
    r.frame_done = w.end_of_frame;
    if (w.end_of_frame) begin
      len = int'(frame_len);
      if (!header_ok) r.verdict = VERDICT_FRAMING;
      else if (!id_ok) r.verdict = VERDICT_NOADDR;
      else if (len < 3 || len - 3 > PARAM_LIMIT || int'(idx) + 1 != len + 5)
        r.verdict = VERDICT_FRAMING;
      else if (crc_acc != rx_crc) r.verdict = VERDICT_CRC;
      else begin
        r.verdict = VERDICT_OK;
        r.param_count = 7'(len - 3);
      end
      if (r.verdict == VERDICT_FRAMING) sticky = sticky | STICKY_FRAMING;
      if (r.verdict == VERDICT_CRC) sticky = sticky | STICKY_CRC;
      rearm_tracker();
    end
    r.sticky_errors = sticky;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_LINES) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      case (idx)
        REG_OWN_ID: cfg_own_id = val;
        REG_SYNC_FIRST: cfg_sync_first = val;
        REG_SYNC_SECOND: cfg_sync_second = val;
        default: ;
      endcase
    end else if (prdata[7:0] !== val) begin
      report_mismatch($sformatf("register %0d reads %0h want %0h", idx, prdata[7:0], val));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one word, wait for it to be taken, then record what it should produce
  task automatic send_word(input rx_word_t w, input bit typed, input res_word_t want);
    int gap;
    res_word_t predicted;
    if (words_sent % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    gap = rx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_data <= w;
    do @(posedge clk); while (rx_stall);
    words_sent++;
    predicted = track_byte(w);
    expected_words.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic [7:0] d, input bit eof, input bit clr, input int fill,
                         input bit typed, input logic [2:0] role, input logic [1:0] verdict,
                         input logic [1:0] flags);
    stim_row_t row;
    row.w = '{data_byte: d, end_of_frame: eof, clear_errors: clr};
    row.fill = fill;
    row.typed = typed;
    row.want = '{byte_out: d, byte_role: role, frame_done: eof, verdict: verdict,
                 param_count: 7'd0, sticky_errors: flags};
    directed_rows.push_back(row);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] fq [$];
    int n_par;
    int len;
    logic [15:0] acc;
    rx_word_t w;
    res_word_t none;
    none = '0;
    n_par = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, PARAM_LIMIT);
    len = n_par + 3;
    if (kind == FRAME_SHORT_LEN) begin
      len = $urandom_range(0, 2);
      n_par = $urandom_range(0, 3);
    end else if (kind == FRAME_OVERSIZE) begin
      if ($urandom_range(0, 1)) begin
        n_par = $urandom_range(PARAM_LIMIT + 1, PARAM_LIMIT + 3);
        len = n_par + 3;
      end else begin
        len = $urandom_range(PARAM_LIMIT + 4, 65535);
      end
    end
    fq.push_back(cfg_sync_first);
    fq.push_back(cfg_sync_second);
    fq.push_back(cfg_own_id);
    fq.push_back(8'(len));
    fq.push_back(8'(len >> 8));
    fq.push_back(8'($urandom));
    repeat (n_par) fq.push_back(8'($urandom));
    acc = '0;
    foreach (fq[i]) acc = crc16_step(acc, fq[i]);
    fq.push_back(acc[7:0]);
    fq.push_back(acc[15:8]);
    case (kind)
      FRAME_BAD_CRC: fq[fq.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FRAME_WRONG_ID: fq[2] ^= 8'($urandom_range(1, 255));
      FRAME_BAD_HEADER: fq[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FRAME_BAD_COUNT: begin
        if ($urandom_range(0, 1)) void'(fq.pop_back());
        else fq.push_back(8'($urandom));
      end
      FRAME_NOISE: begin
        fq.delete();
        repeat ($urandom_range(1, 12)) fq.push_back(8'($urandom));
      end
      default: ;
    endcase
    foreach (fq[i]) begin
      w.data_byte = fq[i];
      w.end_of_frame = (i == fq.size() - 1);
      w.clear_errors = ($urandom_range(0, 9) == 0);
      send_word(w, 1'b0, none);
    end
  endtask

  task automatic drain_results();
    rx_valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
  endtask

  // result side: random stalls, each word checked against the oldest expectation
  initial begin : result_side
    int hold;
    res_word_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (words_seen % 40 == 0) res_calm = ($urandom_range(0, 3) == 0);
      hold = res_calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (res_valid !== 1'b1);
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %0h with nothing expected", res_data));
      end else begin
        want = expected_words.pop_front();
        if (res_data.byte_out !== want.byte_out)
          report_mismatch($sformatf("byte_out %0h want %0h", res_data.byte_out, want.byte_out));
        if (res_data.byte_role !== want.byte_role)
          report_mismatch($sformatf("byte_role %0d want %0d on byte %0h",
                                    res_data.byte_role, want.byte_role, want.byte_out));
        if (res_data.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done %0b want %0b",
                                    res_data.frame_done, want.frame_done));
        if (res_data.verdict !== want.verdict)
          report_mismatch($sformatf("verdict %0d want %0d", res_data.verdict, want.verdict));
        if (res_data.param_count !== want.param_count)
          report_mismatch($sformatf("param_count %0d want %0d",
                                    res_data.param_count, want.param_count));
        if (res_data.sticky_errors !== want.sticky_errors)
          report_mismatch($sformatf("sticky_errors %0b want %0b",
                                    res_data.sticky_errors, want.sticky_errors));
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    rx_word_t w;
    logic [15:0] run_crc;
    logic [7:0] own, s1, s2;
    int r;

    cfg_own_id = OWN_ID_RESET;
    cfg_sync_first = SYNC_FIRST_RESET;
    cfg_sync_second = SYNC_SECOND_RESET;
    sticky = STICKY_NONE;
    rearm_tracker();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_access(1'b0, REG_OWN_ID, OWN_ID_RESET);
    reg_access(1'b0, REG_SYNC_FIRST, SYNC_FIRST_RESET);
    reg_access(1'b0, REG_SYNC_SECOND, SYNC_SECOND_RESET);

    // well-formed frame with no parameters
    add_row(SYNC_FIRST_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(SYNC_SECOND_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(OWN_ID_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h03, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h5A, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 0, 0, FILL_CRC_LO, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 1, 0, FILL_CRC_HI, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    // bad header, two bytes only
    add_row(8'h00, 0, 0, FILL_NONE, 1, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'hFF, 1, 0, FILL_NONE, 1, ROLE_HEADER, VERDICT_FRAMING, STICKY_FRAMING);
    // addressed elsewhere: dropped, no flag
    add_row(SYNC_FIRST_RESET, 0, 0, FILL_NONE, 1, ROLE_HEADER, VERDICT_OK, STICKY_FRAMING);
    add_row(SYNC_SECOND_RESET, 0, 0, FILL_NONE, 1, ROLE_HEADER, VERDICT_OK, STICKY_FRAMING);
    add_row(8'h00, 1, 0, FILL_NONE, 1, ROLE_ID, VERDICT_NOADDR, STICKY_FRAMING);
    // clear and a fresh framing error on the same word
    add_row(8'hFF, 1, 1, FILL_NONE, 1, ROLE_HEADER, VERDICT_FRAMING, STICKY_FRAMING);
    // clear, then a header-only frame fails on length
    add_row(SYNC_FIRST_RESET, 0, 1, FILL_NONE, 1, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(SYNC_SECOND_RESET, 1, 0, FILL_NONE, 1, ROLE_HEADER, VERDICT_FRAMING,
            STICKY_FRAMING);
    // right shape, zero crc field
    add_row(SYNC_FIRST_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(SYNC_SECOND_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(OWN_ID_RESET, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h03, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 0, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);
    add_row(8'h00, 1, 0, FILL_NONE, 0, ROLE_HEADER, VERDICT_OK, STICKY_NONE);

    run_crc = '0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      w = row.w;
      if (row.fill == FILL_CRC_LO) w.data_byte = run_crc[7:0];
      else if (row.fill == FILL_CRC_HI) w.data_byte = run_crc[15:8];
      else run_crc = crc16_step(run_crc, w.data_byte);
      if (w.end_of_frame) run_crc = '0;
      send_word(w, row.typed, row.want);
    end
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: {own, s1, s2} = {OWN_ID_RESET, SYNC_FIRST_RESET, SYNC_SECOND_RESET};
        1: {own, s1, s2} = {8'h00, 8'hFF, 8'h00};
        2: {own, s1, s2} = {8'hFF, 8'h00, 8'hFF};
        default: {own, s1, s2} = {8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      reg_access(1'b1, REG_OWN_ID, own);
      reg_access(1'b1, REG_SYNC_FIRST, s1);
      reg_access(1'b1, REG_SYNC_SECOND, s2);
      reg_access(1'b0, REG_OWN_ID, own);
      reg_access(1'b0, REG_SYNC_FIRST, s1);
      reg_access(1'b0, REG_SYNC_SECOND, s2);

      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 50) send_frame(FRAME_GOOD);
        else if (r < 62) send_frame(FRAME_BAD_CRC);
        else if (r < 70) send_frame(FRAME_WRONG_ID);
        else if (r < 78) send_frame(FRAME_BAD_HEADER);
        else if (r < 86) send_frame(FRAME_BAD_COUNT);
        else if (r < 90) send_frame(FRAME_SHORT_LEN);
        else if (r < 95) send_frame(FRAME_OVERSIZE);
        else send_frame(FRAME_NOISE);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
